// ===== hdl/scdf_pkg.sv =====
package scdf_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned BinW       = 32;
  localparam int unsigned ProbW      = 17;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_COMPACT = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef struct packed {
    logic [BinW-1:0]  bin;
    logic [ProbW-1:0] prob;
  } entry_t;

  typedef struct packed {
    logic             ins_go;
    logic [BinW-1:0]  ins_bin;
    logic [ProbW-1:0] ins_prob;
    logic             rot;
    entry_t           wr_entry;
  } cell_ctl_t;

endpackage

// ===== hdl/scdf_cell.sv =====
module scdf_cell import scdf_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      active_i,
  input  logic      at_end_i,
  input  logic      wr_i,
  input  logic      left_less_i,
  input  entry_t    left_i,
  input  entry_t    right_i,
  output entry_t    entry_o,
  output logic      less_o
);

  entry_t entry_q, entry_d;

  assign entry_o = entry_q;
  assign less_o  = active_i && ($signed(ctl_i.ins_bin) < $signed(entry_q.bin));

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.rot) begin
      entry_d = wr_i ? ctl_i.wr_entry : right_i;
    end else if (ctl_i.ins_go && (active_i || at_end_i)) begin
      if (left_less_i) begin
        entry_d = left_i;
      end else if (less_o || at_end_i) begin
        entry_d = '{bin: ctl_i.ins_bin, prob: ctl_i.ins_prob};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== hdl/scdf_row.sv =====
module scdf_row import scdf_pkg::*; (
  input  logic             clk_i,
  input  logic             ins_i,
  input  logic [BinW-1:0]  bin_i,
  input  logic [ProbW-1:0] prob_i,
  input  logic             rot_i,
  input  logic             wr_i,
  input  logic [IdxW-1:0]  wr_pos_i,
  input  logic [CntW-1:0]  count_i,
  output entry_t           head_o
);

  cell_ctl_t ctl;
  entry_t    ent  [TableDepth];
  logic      less [TableDepth];

  assign ctl = '{ins_go: ins_i, ins_bin: bin_i, ins_prob: prob_i, rot: rot_i,
                 wr_entry: ent[0]};

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    scdf_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .active_i    (CntW'(g) < count_i),
      .at_end_i    (CntW'(g) == count_i),
      .wr_i        (wr_i && (IdxW'(g) == wr_pos_i)),
      .left_less_i ((g > 0) && less[(g + TableDepth - 1) % TableDepth]),
      .left_i      (ent[(g + TableDepth - 1) % TableDepth]),
      .right_i     (ent[(g + 1) % TableDepth]),
      .entry_o     (ent[g]),
      .less_o      (less[g])
    );
  end

  assign head_o = ent[0];

endmodule

// ===== hdl/sorted_cdf_table_inverse_lookup_core.sv =====
// Inverse-CDF table with valid/ready channels on both sides.
// Input beat: opcode_i, bin_value_i, probability_i. Output beat: result_bin_o,
// status_o, entry_count_o, one per input beat.
// The table is a row of TableDepth cells kept sorted by bin.
// Insert and clear: at the accept edge insert updates the row and clear empties
// the count; the result then goes through S_OUT into the output register.
// Compact and query rotate the whole row once, through all TableDepth cells, in
// S_ROT before the result goes through S_OUT into the output register. In every
// case the next beat can be taken once the result is loaded there.
// Query scans entries as they pass the row head; compact writes each kept
// entry into the cell that lands on its packed slot when the rotation ends.
// One beat is worked on at a time; in_ready_o is high only while idle. The
// output register parts the two sides: while a result waits there the next
// beat is still taken and worked on, and its result is held until the
// register frees up, which blocks further input.
// Reset empties the table (count zero) and drops any pending result; entry
// contents are left as they are and are never read before being written.
module sorted_cdf_table_inverse_lookup_core import scdf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              opcode_i,
  input  logic signed [BinW-1:0]  bin_value_i,
  input  logic [ProbW-1:0]        probability_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [BinW-1:0]  result_bin_o,
  output logic                    status_o,
  output logic [6:0]              entry_count_o
);

  typedef enum logic [1:0] { S_IDLE, S_ROT, S_OUT } state_e;

  state_e           state_q;
  op_e              op_q;
  logic [ProbW-1:0] prob_q;
  logic [CntW-1:0]  count_q, kept_q;
  logic [CntW-1:0]  step_q;
  logic [ProbW-1:0] last_q;
  logic             found_q;
  logic [BinW-1:0]  res_q;
  logic             stat_q;
  logic             out_valid_q;
  logic [BinW-1:0]  out_bin_q;
  logic             out_stat_q;
  logic [6:0]       out_cnt_q;
  entry_t           head;
  logic             accept, rot, ins, full, keep, out_load;
  logic [IdxW-1:0]  wr_pos;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q >= CntW'(TableDepth));
  assign ins        = accept && (op_e'(opcode_i) == OP_INSERT) && !full;
  assign rot        = (state_q == S_ROT);
  assign keep       = rot && (op_q == OP_COMPACT) && (step_q < count_q) &&
                      (head.prob != last_q);
  // kept entry goes to the cell that reaches its packed slot after the rotation
  assign wr_pos     = IdxW'(TableDepth - 1) - step_q[IdxW-1:0] + kept_q[IdxW-1:0];
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  scdf_row u_row (
    .clk_i    (clk_i),
    .ins_i    (ins),
    .bin_i    (bin_value_i),
    .prob_i   (probability_i),
    .rot_i    (rot),
    .wr_i     (keep),
    .wr_pos_i (wr_pos),
    .count_i  (count_q),
    .head_o   (head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      op_q        <= OP_INSERT;
      prob_q      <= '0;
      kept_q      <= '0;
      step_q      <= '0;
      last_q      <= '0;
      found_q     <= 1'b0;
      res_q       <= '0;
      stat_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_bin_q   <= '0;
      out_stat_q  <= 1'b0;
      out_cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= op_e'(opcode_i);
            prob_q  <= probability_i;
            step_q  <= '0;
            kept_q  <= '0;
            last_q  <= '0;
            found_q <= 1'b0;
            res_q   <= '0;
            stat_q  <= 1'b0;
            unique case (op_e'(opcode_i))
              OP_INSERT: begin
                if (full) stat_q <= 1'b1;
                else count_q <= count_q + 1'b1;
                state_q <= S_OUT;
              end
              OP_CLEAR: begin
                count_q <= '0;
                state_q <= S_OUT;
              end
              default: state_q <= S_ROT;
            endcase
          end
        end
        S_ROT: begin
          step_q <= step_q + 1'b1;
          if (op_q == OP_QUERY) begin
            if (step_q < count_q && !found_q) begin
              if (step_q == '0) begin
                res_q <= head.bin;
                if (count_q == CntW'(1) || prob_q <= head.prob) found_q <= 1'b1;
              end else begin
                res_q <= head.bin;
                if (head.prob >= prob_q) found_q <= 1'b1;
              end
            end
          end else if (keep) begin
            last_q <= head.prob;
            kept_q <= kept_q + 1'b1;
          end
          if (step_q == CntW'(TableDepth - 1)) begin
            state_q <= S_OUT;
            if (op_q == OP_COMPACT) count_q <= kept_q + CntW'(keep);
          end
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_bin_q   <= (op_q == OP_QUERY) ? res_q : '0;
        out_stat_q  <= stat_q;
        out_cnt_q   <= 7'(count_q);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_bin_o  = out_bin_q;
  assign status_o      = out_stat_q;
  assign entry_count_o = out_cnt_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_bin_o) &&
    $stable(status_o) && $stable(entry_count_o)) else $error("output beat changed");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth)) else $error("count overflow");
  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> entry_count_o == 7'(TableDepth)) else $error("bad status");

endmodule

// ===== dv/tb_sorted_cdf_table_inverse_lookup_core.sv =====
`timescale 1ns / 1ps

module tb_sorted_cdf_table_inverse_lookup_core;
  import scdf_pkg::*;

  typedef struct {
    logic signed [BinW-1:0] bin;
    logic                   status;
    logic [6:0]             count;
  } answer_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             opcode_i = OP_CLEAR;
  logic signed [BinW-1:0] bin_value_i = '0;
  logic [ProbW-1:0]       probability_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [BinW-1:0] result_bin_o;
  logic                   status_o;
  logic [6:0]             entry_count_o;

  logic signed [BinW-1:0] tbl_bin [TableDepth];
  logic [ProbW-1:0]       tbl_prob [TableDepth];
  int unsigned            tbl_used = 0;
  answer_t                pending_answers [$];
  int                     mismatches = 0;
  int                     idle_cycles = 0;
  int                     out_wait = 0;
  logic                   done = 1'b0;

  always #1 clk_i = ~clk_i;

  sorted_cdf_table_inverse_lookup_core DUT (.*);

  function automatic answer_t table_apply(op_e op, logic signed [BinW-1:0] b,
                                          logic [ProbW-1:0] p);
    answer_t a;
    int unsigned k;
    int unsigned kept;
    logic [ProbW-1:0] last;
    a.bin = '0;
    a.status = 1'b0;
    case (op)
      OP_INSERT: begin
        if (tbl_used >= TableDepth) begin
          a.status = 1'b1;
        end else begin
          k = tbl_used;
          while (k > 0 && b < tbl_bin[k-1]) begin
            tbl_bin[k] = tbl_bin[k-1];
            tbl_prob[k] = tbl_prob[k-1];
            k--;
          end
          tbl_bin[k] = b;
          tbl_prob[k] = p;
          tbl_used++;
        end
      end
      OP_COMPACT: begin
        last = '0;
        kept = 0;
        for (k = 0; k < tbl_used; k++) begin
          if (tbl_prob[k] != last) begin
            last = tbl_prob[k];
            tbl_bin[kept] = tbl_bin[k];
            tbl_prob[kept] = tbl_prob[k];
            kept++;
          end
        end
        tbl_used = kept;
      end
      OP_QUERY: begin
        if (tbl_used == 0) a.bin = '0;
        else if (tbl_used == 1 || p <= tbl_prob[0]) a.bin = tbl_bin[0];
        else begin
          a.bin = tbl_bin[tbl_used-1];
          for (k = 1; k < tbl_used; k++) begin
            if (tbl_prob[k] >= p) begin
              a.bin = tbl_bin[k];
              break;
            end
          end
        end
      end
      default: tbl_used = 0;
    endcase
    a.count = tbl_used[6:0];
    return a;
  endfunction

  task automatic send_beat(op_e op, logic signed [BinW-1:0] b, logic [ProbW-1:0] p);
    int gap;
    answer_t a;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    bin_value_i <= b;
    probability_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    a = table_apply(op, b, p);
    pending_answers = {pending_answers, a};
  endtask

  function automatic logic [ProbW-1:0] rand_prob();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      3: return ProbW'($urandom_range(0, 8) * 17'd8192);
      default: return ProbW'($urandom_range(0, 17'h1FFFF));
    endcase
  endfunction

  function automatic logic signed [BinW-1:0] rand_bin();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return $signed(32'($urandom_range(0, 15)) - 32'd8) <<< 16;
      default: return $signed($urandom());
    endcase
  endfunction

  always @(posedge clk_i) begin
    int w;
    if (!rst_ni || done) begin
      out_ready_i <= 1'b0;
      out_wait <= 0;
    end else if (out_valid_o && out_ready_i) begin
      w = $urandom_range(0, 16);
      out_ready_i <= (w == 0);
      out_wait <= w;
    end else if (out_wait > 1) begin
      out_wait <= out_wait - 1;
    end else begin
      out_wait <= 0;
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        if (pending_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat bin=%0d", result_bin_o);
        end else begin
          e = pending_answers.pop_front();
          if (e.bin !== result_bin_o || e.status !== status_o || e.count !== entry_count_o)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp bin=%0d st=%0d cnt=%0d got bin=%0d st=%0d cnt=%0d",
                       e.bin, e.status, e.count, result_bin_o, status_o, entry_count_o);
          end
        end
      end
      if (idle_cycles > 5000) begin
        $display("tb_sorted_cdf_table_inverse_lookup_core: errors");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_beat(OP_QUERY, 0, 17'd100);
    send_beat(OP_COMPACT, 0, 0);
    send_beat(OP_INSERT, 32'sh7FFF_FFFF, 17'd65536);
    send_beat(OP_QUERY, 0, 17'h1FFFF);
    send_beat(OP_INSERT, 32'sh8000_0000, 17'd0);
    send_beat(OP_INSERT, 32'sh0001_0000, 17'h1FFFF);
    send_beat(OP_INSERT, 32'sh0001_0000, 17'd32768);
    send_beat(OP_INSERT, 32'sh0002_0000, 17'd32768);
    send_beat(OP_QUERY, 0, 17'd0);
    send_beat(OP_QUERY, 0, 17'd32768);
    send_beat(OP_QUERY, 0, 17'd40000);
    send_beat(OP_QUERY, 0, 17'h1FFFF);
    send_beat(OP_COMPACT, 0, 0);
    send_beat(OP_QUERY, 0, 17'd1);
    send_beat(OP_CLEAR, 32'shFFFF_FFFF, 17'h1FFFF);
    send_beat(OP_QUERY, 0, 17'd5);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < TableDepth + 3; i++) send_beat(OP_INSERT, rand_bin(), rand_prob());
    send_beat(OP_QUERY, 0, rand_prob());
    send_beat(OP_COMPACT, 0, 0);
    send_beat(OP_CLEAR, 0, 0);
  endtask

  task automatic test_random();
    int n;
    int fill;
    n = 0;
    while (n < 1100) begin
      fill = $urandom_range(0, 3) == 0 ? $urandom_range(40, 70) : $urandom_range(1, 12);
      for (int i = 0; i < fill; i++) begin
        send_beat(OP_INSERT, rand_bin(), rand_prob());
        n++;
        if ($urandom_range(0, 7) == 0) begin
          send_beat(op_e'($urandom_range(1, 2)), rand_bin(), rand_prob());
          n++;
        end
      end
      for (int i = 0; i < $urandom_range(1, 6); i++) begin
        send_beat(op_e'($urandom_range(0, 4) == 0 ? OP_COMPACT : OP_QUERY),
                  rand_bin(), rand_prob());
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        send_beat(OP_CLEAR, rand_bin(), rand_prob());
        n++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    done <= 1'b1;
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("tb_sorted_cdf_table_inverse_lookup_core: clean");
    end else begin
      $display("tb_sorted_cdf_table_inverse_lookup_core: errors");
    end
    $finish;
  end
endmodule

// ===== sorted_cdf_table_inverse_lookup_core.f =====
hdl/scdf_pkg.sv
hdl/scdf_cell.sv
hdl/scdf_row.sv
hdl/sorted_cdf_table_inverse_lookup_core.sv
dv/tb_sorted_cdf_table_inverse_lookup_core.sv
